### hw/rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: shared types, constants and the
// seven-segment lookup. No dependencies.
`timescale 1ns / 1ps

package ps2md_pkg;

   // Byte and field widths.
   localparam int BYTE_W   = 8;
   localparam int DELTA_W  = 9;
   localparam int POS_W    = 16;
   localparam int SHIFT_W  = 3;
   localparam int SEG_W    = 8;
   localparam int DIGITS   = 6;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Reset value of the delta shift register.
   localparam logic [SHIFT_W-1:0] DELTA_SHIFT_RESET = 3'd4;

   // Bit positions in the first packet byte.
   localparam int LEFT_BIT       = 0;
   localparam int RIGHT_BIT      = 1;
   localparam int ALWAYS_ONE_BIT = 3;
   localparam int DX_NEG_BIT     = 4;
   localparam int DY_NEG_BIT     = 5;

   // Power-on sequence from the mouse: self-test passed, then device ID.
   localparam logic [BYTE_W-1:0] SELF_TEST_OK = 8'hAA;
   localparam logic [BYTE_W-1:0] MOUSE_ID     = 8'h00;

   // One classified window, passed from the front to the back.
   typedef struct packed {
      logic              packet;
      logic              enable;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [BYTE_W-1:0] b3;
   } ps2md_item_type;

   typedef logic [SEG_W-1:0] seg_array_type [16];

   localparam seg_array_type SEG_CODES = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h67, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
   };

   // Seven-segment code of one hex digit.
   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] nibble);
      return SEG_CODES[nibble];
   endfunction

endpackage

### hw/rtl/ps2md_if.sv
// Channel interfaces of the PS/2 mouse packet decoder: received bytes,
// decoded results and the configuration write channel. Depends on ps2md_pkg.
`timescale 1ns / 1ps

interface ps2md_req_if;
   logic                        valid;
   logic                        ready;
   logic [ps2md_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2md_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                packet_valid;
   logic                                left_button;
   logic                                right_button;
   logic signed [ps2md_pkg::DELTA_W-1:0] delta_x;
   logic signed [ps2md_pkg::DELTA_W-1:0] delta_y;
   logic signed [ps2md_pkg::POS_W-1:0]   x_position;
   logic signed [ps2md_pkg::POS_W-1:0]   y_position;
   logic [31:0]                         segs_low;
   logic [15:0]                         segs_high;
   logic                                send_enable_cmd;

   modport source (output valid, output packet_valid, output left_button,
                   output right_button, output delta_x, output delta_y,
                   output x_position, output y_position, output segs_low,
                   output segs_high, output send_enable_cmd, input ready);
   modport sink   (input valid, input packet_valid, input left_button,
                   input right_button, input delta_x, input delta_y,
                   input x_position, input y_position, input segs_low,
                   input segs_high, input send_enable_cmd, output ready);
endinterface

interface ps2md_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ps2md_pkg::SHIFT_W-1:0] delta_shift;

   modport source (output valid, output delta_shift, input ready);
   modport sink   (input valid, input delta_shift, output ready);
endinterface

### hw/rtl/ps2md_front.sv
// Front of the PS/2 mouse packet decoder: keeps the byte window and
// classifies each window. Depends on ps2md_pkg and ps2md_if.
`timescale 1ns / 1ps

module ps2md_front (
   input  logic                      clock,
   input  logic                      reset,
   ps2md_req_if.sink                 req_ch,
   output logic                      push_valid,
   input  logic                      push_ready,
   output ps2md_pkg::ps2md_item_type push_item
);
   import ps2md_pkg::*;

   logic [BYTE_W-1:0] window_old_ff, window_old_in;
   logic [BYTE_W-1:0] window_mid_ff, window_mid_in;
   logic              accept;

   // A byte is taken whenever the queue has room.
   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;

   // Classify the window formed by the two held bytes and the new one.
   always_comb begin
      push_item.b1     = window_old_ff;
      push_item.b2     = window_mid_ff;
      push_item.b3     = req_ch.rx_byte;
      push_item.packet = window_old_ff[ALWAYS_ONE_BIT];
      push_item.enable = (window_mid_ff == SELF_TEST_OK) &&
                         (req_ch.rx_byte == MOUSE_ID);
   end

   // Slide the window on every transfer.
   always_comb begin
      window_old_in = window_old_ff;
      window_mid_in = window_mid_ff;
      if (accept) begin
         window_old_in = window_mid_ff;
         window_mid_in = req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_old_ff <= '0;
         window_mid_ff <= '0;
      end else begin
         window_old_ff <= window_old_in;
         window_mid_ff <= window_mid_in;
      end
   end

endmodule

### hw/rtl/ps2md_queue.sv
// Short queue between the front and the back of the PS/2 mouse packet
// decoder. Depends on ps2md_pkg.
`timescale 1ns / 1ps

module ps2md_queue #(
   parameter int DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  ps2md_pkg::ps2md_item_type push_item,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output ps2md_pkg::ps2md_item_type pop_item
);
   import ps2md_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ps2md_item_type   storage_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = storage_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         storage_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/ps2md_back.sv
// Back of the PS/2 mouse packet decoder: scales deltas, accumulates position,
// builds segment codes and drives the result register. Depends on ps2md_pkg
// and ps2md_if.
`timescale 1ns / 1ps

module ps2md_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  ps2md_pkg::ps2md_item_type pop_item,
   ps2md_csr_if.sink                 csr_ch,
   ps2md_rsp_if.source               rsp_ch
);
   import ps2md_pkg::*;

   logic [SHIFT_W-1:0]       delta_shift_ff, delta_shift_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     packet_ff, packet_in;
   logic                     enable_ff, enable_in;
   logic [1:0]               buttons_ff, buttons_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic [POS_W-1:0]         pos_x_ff, pos_x_in;
   logic [POS_W-1:0]         pos_y_ff, pos_y_in;
   logic [DIGITS*SEG_W-1:0]  segs_ff, segs_in;

   logic                     pop_fire;
   logic signed [DELTA_W-1:0] dx_ext, dy_ext;
   logic signed [DELTA_W-1:0] dx_scaled, dy_scaled;
   logic [3*BYTE_W-1:0]      word;
   logic [DIGITS*SEG_W-1:0]  segs_new;

   // Configuration register: always ready; the user must write it only while idle, which the block does not enforce.
   assign csr_ch.ready = 1'b1;
   assign delta_shift_in = csr_ch.valid ? csr_ch.delta_shift : delta_shift_ff;

   // Take the next item when the result register is empty or being drained.
   assign pop_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop_fire  = pop_valid && pop_ready;

   // Nine-bit sign extension followed by an arithmetic shift.
   always_comb begin
      dx_ext    = $signed({pop_item.b1[DX_NEG_BIT], pop_item.b2});
      dy_ext    = $signed({pop_item.b1[DY_NEG_BIT], pop_item.b3});
      dx_scaled = dx_ext >>> delta_shift_ff;
      dy_scaled = dy_ext >>> delta_shift_ff;
   end

   // Segment codes of the six hex digits, lowest digit in the low byte.
   assign word = {pop_item.b1, pop_item.b2, pop_item.b3};
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         segs_new[i*SEG_W +: SEG_W] = seg_code(word[i*4 +: 4]);
      end
   end

   // Latched state and the result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      packet_in    = packet_ff;
      enable_in    = enable_ff;
      buttons_in   = buttons_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      segs_in      = segs_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop_fire) begin
         rsp_valid_in = 1'b1;
         packet_in    = pop_item.packet;
         enable_in    = pop_item.enable;
         if (pop_item.packet) begin
            buttons_in = {pop_item.b1[RIGHT_BIT], pop_item.b1[LEFT_BIT]};
            dx_in      = dx_scaled;
            dy_in      = dy_scaled;
            pos_x_in   = pos_x_ff +
                         {{(POS_W-DELTA_W){dx_scaled[DELTA_W-1]}}, dx_scaled};
            pos_y_in   = pos_y_ff +
                         {{(POS_W-DELTA_W){dy_scaled[DELTA_W-1]}}, dy_scaled};
            segs_in    = segs_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_shift_ff <= DELTA_SHIFT_RESET;
         rsp_valid_ff   <= 1'b0;
         packet_ff      <= 1'b0;
         enable_ff      <= 1'b0;
         buttons_ff     <= '0;
         dx_ff          <= '0;
         dy_ff          <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         segs_ff        <= '0;
      end else begin
         delta_shift_ff <= delta_shift_in;
         rsp_valid_ff   <= rsp_valid_in;
         packet_ff      <= packet_in;
         enable_ff      <= enable_in;
         buttons_ff     <= buttons_in;
         dx_ff          <= dx_in;
         dy_ff          <= dy_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         segs_ff        <= segs_in;
      end
   end

   // Result fields come straight from the registers.
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.packet_valid    = packet_ff;
   assign rsp_ch.left_button     = buttons_ff[0];
   assign rsp_ch.right_button    = buttons_ff[1];
   assign rsp_ch.delta_x         = dx_ff;
   assign rsp_ch.delta_y         = dy_ff;
   assign rsp_ch.x_position      = $signed(pos_x_ff);
   assign rsp_ch.y_position      = $signed(pos_y_ff);
   assign rsp_ch.segs_low        = segs_ff[31:0];
   assign rsp_ch.segs_high       = segs_ff[47:32];
   assign rsp_ch.send_enable_cmd = enable_ff;

endmodule

### hw/rtl/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder. Every byte transferred on req_ch yields one
// result on rsp_ch, in order. The block takes one byte per clock cycle while
// req_ch.ready is high; each byte's item is registered in the queue storage
// and its result in the back result register, and a stalled result side is
// absorbed by the QUEUE_DEPTH-entry queue before req_ch.ready drops. A packet
// is taken whenever the oldest of the last three bytes has bit 3 set; its
// buttons, shifted deltas, 16-bit wrapping positions and seven-segment codes
// are held until the next packet. delta_shift (reset 4) is for the user to write
// on csr_ch only while no byte is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder #(
   parameter int QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ps2md_req_if.sink   req_ch,
   ps2md_rsp_if.source rsp_ch,
   ps2md_csr_if.sink   csr_ch
);
   import ps2md_pkg::*;

   logic           push_valid;
   logic           push_ready;
   ps2md_item_type push_item;
   logic           pop_valid;
   logic           pop_ready;
   ps2md_item_type pop_item;

   // Window and classification.
   ps2md_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Decoupling queue.
   ps2md_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Decode and accumulate.
   ps2md_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule

### sim/tb_ps2_mouse_packet_decoder.sv
// Self-checking testbench for the PS/2 mouse packet decoder: directed and random byte
// streams under several handshake idling phases and delta shift settings.
// Depends on ps2md_pkg, the channel interfaces in ps2md_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder;
   import ps2md_pkg::*;

   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 3;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 412;
   localparam int MAX_REPORTS    = 10;

   // Directed stream: power-on sequence, packets at the delta and button extremes,
   // bytes with bit 3 clear, unaligned windows and a repeated enable sequence.
   localparam int DIRECTED_LEN = 25;
   localparam logic [8*DIRECTED_LEN-1:0] DIRECTED_BYTES = {
      8'hAA, 8'h00, 8'h08, 8'h00, 8'h00, 8'h3B, 8'h00, 8'h00, 8'h09, 8'hFF,
      8'h7F, 8'h2A, 8'h80, 8'h01, 8'hF7, 8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'h0B,
      8'hAA, 8'h00, 8'hF4, 8'h18, 8'h01
   };

   // One decoded result as seen on the result channel.
   typedef struct packed {
      logic               packet_valid;
      logic               left_button;
      logic               right_button;
      logic [DELTA_W-1:0] delta_x;
      logic [DELTA_W-1:0] delta_y;
      logic [POS_W-1:0]   x_position;
      logic [POS_W-1:0]   y_position;
      logic [31:0]        segs_low;
      logic [15:0]        segs_high;
      logic               send_enable_cmd;
   } mouse_report_type;

   logic clock;
   logic reset;

   ps2md_req_if req_ch ();
   ps2md_rsp_if rsp_ch ();
   ps2md_csr_if csr_ch ();

   ps2_mouse_packet_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Bytes waiting to be driven and decoded results waiting to arrive.
   logic [BYTE_W-1:0] pending_bytes[$];
   mouse_report_type  expected_reports[$];

   // Decoder state as predicted by the testbench.
   logic [SHIFT_W-1:0]    shift_setting = DELTA_SHIFT_RESET;
   logic [BYTE_W-1:0]     win_old       = '0;
   logic [BYTE_W-1:0]     win_mid       = '0;
   logic [POS_W-1:0]      acc_x         = '0;
   logic [POS_W-1:0]      acc_y         = '0;
   logic [1:0]            held_buttons  = '0;
   logic [DELTA_W-1:0]    held_dx       = '0;
   logic [DELTA_W-1:0]    held_dy       = '0;
   logic [SEG_W*DIGITS-1:0] held_segs   = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Seven-segment pattern of one hex digit, segment a in bit 0.
   function automatic logic [SEG_W-1:0] hex_to_seg(input logic [3:0] digit);
      case (digit)
         4'h0: return 8'h3F;
         4'h1: return 8'h06;
         4'h2: return 8'h5B;
         4'h3: return 8'h4F;
         4'h4: return 8'h66;
         4'h5: return 8'h6D;
         4'h6: return 8'h7D;
         4'h7: return 8'h07;
         4'h8: return 8'h7F;
         4'h9: return 8'h67;
         4'hA: return 8'h77;
         4'hB: return 8'h7C;
         4'hC: return 8'h39;
         4'hD: return 8'h5E;
         4'hE: return 8'h79;
         default: return 8'h71;
      endcase
   endfunction

   // Nine-bit delta from a sign bit and a magnitude byte, scaled by the shift setting.
   function automatic logic [DELTA_W-1:0] scaled_delta(input logic neg,
                                                      input logic [BYTE_W-1:0] mag);
      logic signed [DELTA_W-1:0] raw;
      raw = {neg, mag};
      return raw >>> shift_setting;
   endfunction

   // Advances the predicted window by one byte and returns the result it causes.
   function automatic mouse_report_type decode_byte(input logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [23:0]       word;
      logic              packet;
      mouse_report_type  r;
      int                i;
      b1 = win_old;
      b2 = win_mid;
      packet = b1[ALWAYS_ONE_BIT];
      win_old = b2;
      win_mid = rx;
      if (packet) begin
         word = {b1, b2, rx};
         for (i = 0; i < DIGITS; i++) begin
            held_segs[SEG_W*i +: SEG_W] = hex_to_seg(word[4*i +: 4]);
         end
         held_buttons = {b1[RIGHT_BIT], b1[LEFT_BIT]};
         held_dx = scaled_delta(b1[DX_NEG_BIT], b2);
         held_dy = scaled_delta(b1[DY_NEG_BIT], rx);
         acc_x = acc_x + {{(POS_W-DELTA_W){held_dx[DELTA_W-1]}}, held_dx};
         acc_y = acc_y + {{(POS_W-DELTA_W){held_dy[DELTA_W-1]}}, held_dy};
      end
      r.packet_valid    = packet;
      r.left_button     = held_buttons[0];
      r.right_button    = held_buttons[1];
      r.delta_x         = held_dx;
      r.delta_y         = held_dy;
      r.x_position      = acc_x;
      r.y_position      = acc_y;
      r.segs_low        = held_segs[31:0];
      r.segs_high       = held_segs[47:32];
      r.send_enable_cmd = (b2 == SELF_TEST_OK) && (rx == MOUSE_ID);
      return r;
   endfunction

   // Counts a wrong field and reports the first few.
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         if (mismatches < MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
         end
         mismatches++;
      end
   endtask

   // Byte for a delta field: the range edges five times in sixteen.
   function automatic logic [BYTE_W-1:0] delta_byte();
      case ($urandom_range(15))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h7F;
         3: return 8'h80;
         4: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly well-formed packets with random content, plus power-on sequences,
   // cut-off packets and loose bytes that shift the framing.
   task automatic queue_random_traffic(input int n_bytes);
      int                added;
      int                pick;
      logic [BYTE_W-1:0] head;
      added = 0;
      while (added < n_bytes) begin
         pick = $urandom_range(99);
         head = 8'($urandom_range(255));
         head[ALWAYS_ONE_BIT] = 1'b1;
         if (pick < 70) begin
            pending_bytes.push_back(head);
            pending_bytes.push_back(delta_byte());
            pending_bytes.push_back(delta_byte());
            added += 3;
         end else if (pick < 80) begin
            pending_bytes.push_back(SELF_TEST_OK);
            pending_bytes.push_back(MOUSE_ID);
            added += 2;
         end else if (pick < 88) begin
            pending_bytes.push_back(head);
            pending_bytes.push_back(delta_byte());
            added += 2;
         end else begin
            pending_bytes.push_back(8'($urandom_range(255)));
            added += 1;
         end
      end
   endtask

   // Waits until every byte has been transferred and every result has arrived.
   task automatic wait_until_drained();
      while (pending_bytes.size() != 0 || req_ch.valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One write transfer on the configuration channel.
   task automatic write_delta_shift(input logic [SHIFT_W-1:0] value);
      @(posedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.delta_shift <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      shift_setting = value;
   endtask

   // Byte driver: predicts each transferred byte and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_reports.push_back(decode_byte(req_ch.rx_byte));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= pending_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest expectation.
   always @(posedge clock) begin
      mouse_report_type want;
      mouse_report_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.packet_valid    = rsp_ch.packet_valid;
            got.left_button     = rsp_ch.left_button;
            got.right_button    = rsp_ch.right_button;
            got.delta_x         = rsp_ch.delta_x;
            got.delta_y         = rsp_ch.delta_y;
            got.x_position      = rsp_ch.x_position;
            got.y_position      = rsp_ch.y_position;
            got.segs_low        = rsp_ch.segs_low;
            got.segs_high       = rsp_ch.segs_high;
            got.send_enable_cmd = rsp_ch.send_enable_cmd;
            if (expected_reports.size() == 0) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("%0t: result transfer with none expected: %p", $realtime, got);
               end
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("packet_valid", 32'(want.packet_valid),
                             32'(got.packet_valid));
               compare_field("left_button", 32'(want.left_button),
                             32'(got.left_button));
               compare_field("right_button", 32'(want.right_button),
                             32'(got.right_button));
               compare_field("delta_x", 32'(want.delta_x), 32'(got.delta_x));
               compare_field("delta_y", 32'(want.delta_y), 32'(got.delta_y));
               compare_field("x_position", 32'(want.x_position), 32'(got.x_position));
               compare_field("y_position", 32'(want.y_position), 32'(got.y_position));
               compare_field("segs_low", want.segs_low, got.segs_low);
               compare_field("segs_high", 32'(want.segs_high), 32'(got.segs_high));
               compare_field("send_enable_cmd", 32'(want.send_enable_cmd),
                             32'(got.send_enable_cmd));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus sequence.
   initial begin
      int i;
      int phase;
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.rx_byte     = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.delta_shift = DELTA_SHIFT_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes at the reset shift, with no idling.
      for (i = 0; i < DIRECTED_LEN; i++) begin
         pending_bytes.push_back(DIRECTED_BYTES[8*(DIRECTED_LEN-1-i) +: 8]);
      end
      wait_until_drained();

      // Random phases, each with its own shift setting and idling pattern.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_delta_shift(3'd0);
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               write_delta_shift(3'd7);
               send_idle_pct = 45;
               stall_pct     = 0;
            end
            2: begin
               write_delta_shift(SHIFT_W'($urandom_range(1, 6)));
               send_idle_pct = 0;
               stall_pct     = 45;
            end
            default: begin
               write_delta_shift(SHIFT_W'($urandom_range(7)));
               send_idle_pct = 38;
               stall_pct     = 38;
            end
         endcase
         queue_random_traffic(PHASE_BYTES);
         wait_until_drained();
      end

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/ps2md_pkg.sv
hw/rtl/ps2md_if.sv
hw/rtl/ps2md_front.sv
hw/rtl/ps2md_queue.sv
hw/rtl/ps2md_back.sv
hw/rtl/ps2_mouse_packet_decoder.sv
sim/tb_ps2_mouse_packet_decoder.sv
